### rtl/core/rdf_pkg.sv
package rdf_pkg;

  localparam int unsigned SUM_W   = 32;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned ENTRY_W = SUM_W + TIME_W;
  localparam int unsigned IN_W    = 64;
  localparam int unsigned OUT_W   = 8;
  localparam int unsigned CFG_W   = 32;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_BYPASS    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_KEEP_TIME = 1'b1;

  localparam logic [TIME_W-1:0] KEEP_TIME_RST = 32'd1000;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture the item, start the ring walk
    logic step;      // evaluate one entry, read the next
    logic append;    // store the pair at the newest end
    logic out_load;  // move the verdict to the output register
  } rdf_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic bypass;
    logic empty;
    logic hit;       // live entry with equal checksum
    logic last;      // entry under test is the newest one
  } rdf_sts_t;

endpackage

### rtl/core/rdf_ram.sv
module rdf_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

### rtl/core/rdf_ctrl.sv
module rdf_ctrl
  import rdf_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      s_tvalid_i,
  output logic      s_tready_o,
  output logic      m_tvalid_o,
  input  logic      m_tready_i,
  input  rdf_sts_t  sts_i,
  output rdf_cmd_t  cmd_o
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_WALK   = 2'd1;
  localparam logic [1:0] ST_APPEND = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0] state_q, state_d;
  logic       m_valid_q, m_valid_d;
  logic       out_free;
  logic       in_fire;

  assign s_tready_o = (state_q == ST_IDLE);
  assign m_tvalid_o = m_valid_q;
  assign in_fire    = s_tready_o & s_tvalid_i;
  assign out_free   = ~m_valid_q | m_tready_i;

  always_comb begin
    cmd_o          = '0;
    cmd_o.load     = in_fire;
    cmd_o.step     = (state_q == ST_WALK);
    cmd_o.append   = (state_q == ST_APPEND);
    cmd_o.out_load = (state_q == ST_FINISH) & out_free;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          priority if (sts_i.bypass) state_d = ST_FINISH;
          else if (sts_i.empty)      state_d = ST_APPEND;
          else                       state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        priority if (sts_i.hit) state_d = ST_FINISH;
        else if (sts_i.last)    state_d = ST_APPEND;
        else                    state_d = ST_WALK;
      end
      ST_APPEND: state_d = ST_FINISH;
      ST_FINISH: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    priority if (cmd_o.out_load) m_valid_d = 1'b1;
    else if (m_tready_i)         m_valid_d = 1'b0;
    else                         m_valid_d = m_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

endmodule

### rtl/core/rdf_dp.sv
module rdf_dp
  import rdf_pkg::*;
#(
  parameter int unsigned RING_DEPTH = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_W-1:0]      cfg_wdata_i,
  input  logic [SUM_W-1:0]      sum_i,
  input  logic [TIME_W-1:0]     now_i,
  output logic                  dup_o,
  input  rdf_cmd_t              cmd_i,
  output rdf_sts_t              sts_o
);

  localparam int unsigned IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(RING_DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(RING_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(RING_DEPTH);

  function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] s);
    if (s == LAST_SLOT) return '0;
    return s + IDX_W'(1);
  endfunction

  logic                 bypass_q;
  logic [TIME_W-1:0]    keep_time_q;
  logic [IDX_W-1:0]     oldest_q, oldest_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [IDX_W-1:0]     cur_q;
  logic [CNT_W-1:0]     left_q;
  logic [SUM_W-1:0]     sum_q;
  logic [TIME_W-1:0]    now_q;
  logic                 dup_q;
  logic                 out_dup_q;

  logic [ENTRY_W-1:0]   rdata;
  logic [TIME_W-1:0]    ent_time;
  logic [SUM_W-1:0]     ent_sum;
  logic [TIME_W-1:0]    age;
  logic                 expired;
  logic [IDX_W-1:0]     cur_next;
  logic [IDX_W-1:0]     raddr;
  logic                 re;

  assign ent_sum  = rdata[SUM_W-1:0];
  assign ent_time = rdata[ENTRY_W-1:SUM_W];
  assign age      = now_q - ent_time;
  assign expired  = (age > keep_time_q);
  assign cur_next = next_slot(cur_q);

  // read ahead: the ring is not written during the walk
  assign re    = cmd_i.load | cmd_i.step;
  assign raddr = cmd_i.load ? oldest_q : cur_next;

  rdf_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (cmd_i.append),
    .waddr_i (cur_q),
    .wdata_i ({now_q, sum_q}),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    sts_o        = '0;
    sts_o.bypass = bypass_q;
    sts_o.empty  = (count_q == '0);
    sts_o.hit    = ~expired & (ent_sum == sum_q);
    sts_o.last   = (left_q == CNT_W'(1));
  end

  always_comb begin
    oldest_d = oldest_q;
    count_d  = count_q;
    if (cmd_i.step && expired) begin
      // drop this entry and every older one
      count_d  = left_q - CNT_W'(1);
      oldest_d = cur_next;
    end else if (cmd_i.append) begin
      if (count_q == FULL_CNT) begin
        oldest_d = next_slot(oldest_q);
      end else begin
        count_d = count_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bypass_q    <= 1'b0;
      keep_time_q <= KEEP_TIME_RST;
      oldest_q    <= '0;
      count_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_BYPASS:    bypass_q    <= cfg_wdata_i[0];
          REG_KEEP_TIME: keep_time_q <= cfg_wdata_i[TIME_W-1:0];
          default:       ;
        endcase
      end
      oldest_q <= oldest_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sum_q  <= sum_i;
      now_q  <= now_i;
      cur_q  <= oldest_q;
      left_q <= count_q;
      dup_q  <= 1'b0;
    end else if (cmd_i.step) begin
      cur_q  <= cur_next;
      left_q <= left_q - CNT_W'(1);
      if (sts_o.hit) dup_q <= 1'b1;
    end
    if (cmd_i.out_load) begin
      out_dup_q <= dup_q;
    end
  end

  assign dup_o = out_dup_q;

endmodule

### rtl/core/recent_duplicate_filter_unit.sv
// Channel   Dir  Fields (low bit first)
// s_axis    in   tdata: frame_checksum[31:0], now_time[63:32]
// m_axis    out  tdata: is_duplicate[0], zero fill [7:1]
// cfg       in   index 0 bypass (wdata[0]), index 1 keep_time (wdata[31:0])
//
// When filtering, an item walks the live ring entries, one a cycle, from the
// registered-read ring memory and stops at the first live match; with no match
// the item is then appended. In bypass the ring is neither walked nor written.
// One item is in work at a time; a new beat is taken once the verdict sits in
// the output register, which holds it while m_axis_tready_i is low.
// Reset empties the ring and sets keep_time to 1000, bypass off.
module recent_duplicate_filter_unit
  import rdf_pkg::*;
#(
  parameter int unsigned RING_DEPTH = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [IN_W-1:0]      s_axis_tdata_i,   // frame_checksum, now_time
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [OUT_W-1:0]     m_axis_tdata_o,   // is_duplicate, zero fill
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i
);

  rdf_cmd_t cmd;
  rdf_sts_t sts;
  logic     dup;

  rdf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rdf_dp #(
    .RING_DEPTH (RING_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .sum_i       (s_axis_tdata_i[SUM_W-1:0]),
    .now_i       (s_axis_tdata_i[SUM_W+TIME_W-1:SUM_W]),
    .dup_o       (dup),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

  assign m_axis_tdata_o = {{(OUT_W-1){1'b0}}, dup};

endmodule

### rtl/core/rdf_checker.sv
module rdf_checker
  import rdf_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid_i,
  input logic                 s_axis_tready_o,
  input logic                 m_axis_tvalid_o,
  input logic                 m_axis_tready_i,
  input logic [OUT_W-1:0]     m_axis_tdata_o
);

  logic in_fire;
  assign in_fire = s_axis_tvalid_i & s_axis_tready_o;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("output beat changed while stalled");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[OUT_W-1:1] == '0)
    else $error("output padding bits not zero");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !s_axis_tready_o)
    else $error("new beat taken while an item is in work");

  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> !$past(in_fire))
    else $error("verdict appeared one cycle after accept");

endmodule

bind recent_duplicate_filter_unit rdf_checker u_rdf_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
